// ----- rtl/core/iprcl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iprcl_pkg - shared types and constants for the IP range country lookup
// Item modes, table entry layout, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
package iprcl_pkg;

	localparam int DEF_TABLE_DEPTH = 1024;
	localparam int DEF_INDEX_SLOTS = 30;

	localparam int ADDR_W  = 32;
	localparam int CODE_W  = 24;
	localparam int MATCH_W = 10;

	// "ZZ", first character in the low byte
	localparam logic [CODE_W-1:0] CODE_NONE = 24'h005A5A;

	typedef enum logic [1:0] {
		MODE_APPEND = 2'd0,
		MODE_BUILD  = 2'd1,
		MODE_LOOKUP = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_BLD_RD,
		ST_BLD_WR,
		ST_IDX_SCAN,
		ST_TBL_SCAN,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic [ADDR_W-1:0] rng_start;
		logic [ADDR_W-1:0] rng_end;
		logic [CODE_W-1:0] code;
	} entry_t;

endpackage

`default_nettype wire

// ----- rtl/core/iprcl_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iprcl_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module iprcl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/core/ip_range_country_lookup_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ip_range_country_lookup_top - IPv4 range table with coarse search index
// Appends ranges, builds a coarse index, looks up addresses, clears the table.
// ----------------------------------------------------------------------------
// Usage:
//  Input words (in_valid/in_stall) carry a mode plus the address or the range
//  to append. Every input word produces exactly one output word
//  (out_valid/out_stall) with status, found, country_code and match_index.
//  One word is in work at a time; in_stall is high from acceptance until the
//  result has moved into the output register.
//  Sequence per mode:
//   append, clear, build with too few entries : straight to the response
//   build  : one divide step for count/slots, then a read and a write per slot
//   lookup : an index probe (built index only), then the table scan; the probe
//            stops at the first qualifying slot, else the scan starts at entry
//            0; the scan stops on a hit or when no entries are left
//  The scan reads one table entry per cycle from the single table RAM read
//  port; in a table sorted by start a hit costs about one partition.
//  The output register decouples the sides: a new word is taken while the
//  previous result still waits under out_stall; a finished result waits in
//  the RESP state until the output register frees up.
//  Reset clears the entry count and the index-built flag; the RAMs are not
//  cleared, entries beyond the count are never read.
// ----------------------------------------------------------------------------
module ip_range_country_lookup_top
	import iprcl_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int INDEX_SLOTS = DEF_INDEX_SLOTS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// input channel
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         mode,
	input  wire logic [ADDR_W-1:0]  ip_address,
	input  wire logic [ADDR_W-1:0]  range_start_in,
	input  wire logic [ADDR_W-1:0]  range_end_in,
	input  wire logic [CODE_W-1:0]  code_in,
	// output channel
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    status,
	output logic                    found,
	output logic      [CODE_W-1:0]  country_code,
	output logic      [MATCH_W-1:0] match_index
);

	// table address, entry count, index address, slot counter widths
	localparam int AW  = $clog2(TABLE_DEPTH);
	localparam int CW  = $clog2(TABLE_DEPTH + 1);
	localparam int IW  = (INDEX_SLOTS > 1) ? $clog2(INDEX_SLOTS) : 1;
	localparam int SW  = $clog2(INDEX_SLOTS + 1);
	localparam int IXW = AW + ADDR_W;                   // index slot: {pos, start}

	// count / slots as (count * QMUL) >> QSH, exact for every count below 2^CW
	localparam int QSH = CW + $clog2(INDEX_SLOTS);
	localparam int MW  = CW + 1;
	localparam int PW  = QSH + CW;
	localparam longint unsigned QMUL_L =
		((64'd1 << QSH) + 64'(INDEX_SLOTS) - 64'd1) / 64'(INDEX_SLOTS);
	localparam logic [MW-1:0] QMUL = MW'(QMUL_L);

	localparam logic [CW-1:0] DEPTH_CNT  = CW'(TABLE_DEPTH);
	localparam logic [CW-1:0] SLOTS_CNT  = CW'(INDEX_SLOTS);
	localparam logic [SW-1:0] SLOTS_SW   = SW'(INDEX_SLOTS);
	localparam logic [SW-1:0] SLOTS_LAST = SW'(INDEX_SLOTS - 1);

	// ---------------------------------------------------------------- state
	state_t            state_q, state_d;
	logic [CW-1:0]     count_q, count_d;
	logic              built_q, built_d;
	logic              pend_s1, pend_d;
	logic              out_valid_q, out_valid_d;

	logic [ADDR_W-1:0] addr_q, addr_d;
	logic [CW-1:0]     quo_q, quo_d;
	logic [CW-1:0]     pos_q, pos_d;
	logic [SW-1:0]     slot_q, slot_d;
	logic [CW-1:0]     scan_q, scan_d;
	logic [CW-1:0]     pidx_s1, pidx_d;

	logic               res_status_q, res_status_d;
	logic               res_found_q, res_found_d;
	logic [CODE_W-1:0]  res_code_q, res_code_d;
	logic [MATCH_W-1:0] res_idx_q, res_idx_d;

	logic               status_q, found_q;
	logic [CODE_W-1:0]  code_q;
	logic [MATCH_W-1:0] idx_q;

	// ---------------------------------------------------------------- memories
	logic          tbl_we;
	logic [AW-1:0] tbl_waddr, tbl_raddr;
	entry_t        tbl_wdata, tbl_rdata;

	logic           idx_we;
	logic [IW-1:0]  idx_waddr, idx_raddr;
	logic [IXW-1:0] idx_wdata, idx_rdata;

	iprcl_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TABLE_DEPTH)
	) u_tbl_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	iprcl_ram #(
		.WIDTH (IXW),
		.DEPTH (INDEX_SLOTS)
	) u_idx_ram (
		.clk   (clk),
		.we    (idx_we),
		.waddr (idx_waddr),
		.wdata (idx_wdata),
		.raddr (idx_raddr),
		.rdata (idx_rdata)
	);

	// ---------------------------------------------------------------- datapath helpers
	logic               accept;
	logic               out_load;
	logic [PW-1:0]      quo_prod;
	logic [CW-1:0]      pos_next;
	logic [AW-1:0]      idx_rd_pos;
	logic [ADDR_W-1:0]  idx_rd_start;
	logic               idx_hit;
	logic               tbl_match;
	logic               issue;
	logic [MATCH_W+CW-1:0] pidx_ext;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_load = (state_q == ST_RESP) && (!out_valid_q || !out_stall);

	// partition length by reciprocal multiplication
	assign quo_prod = PW'(count_q) * PW'(QMUL);

	assign pos_next     = pos_q - quo_q;
	assign idx_rd_pos   = idx_rdata[IXW-1:ADDR_W];
	assign idx_rd_start = idx_rdata[ADDR_W-1:0];
	assign idx_hit      = (addr_q >= idx_rd_start);
	assign tbl_match    = (tbl_rdata.rng_start <= addr_q) && (addr_q <= tbl_rdata.rng_end);
	assign pidx_ext     = {{MATCH_W{1'b0}}, pidx_s1};

	// appends are written at acceptance; all table reads happen in later
	// states, so no read can overlap a write to the same entry
	assign tbl_waddr           = count_q[AW-1:0];
	assign tbl_wdata.rng_start = range_start_in;
	assign tbl_wdata.rng_end   = range_end_in;
	assign tbl_wdata.code      = code_in;

	assign idx_waddr = slot_q[IW-1:0];
	assign idx_wdata = {pos_q[AW-1:0], tbl_rdata.rng_start};

	// ---------------------------------------------------------------- sequencer
	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		built_d      = built_q;
		pend_d       = 1'b0;
		addr_d       = addr_q;
		quo_d        = quo_q;
		pos_d        = pos_q;
		slot_d       = slot_q;
		scan_d       = scan_q;
		pidx_d       = pidx_s1;
		res_status_d = res_status_q;
		res_found_d  = res_found_q;
		res_code_d   = res_code_q;
		res_idx_d    = res_idx_q;
		tbl_we       = 1'b0;
		tbl_raddr    = '0;
		idx_we       = 1'b0;
		idx_raddr    = '0;
		issue        = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					addr_d       = ip_address;
					res_status_d = 1'b0;
					res_found_d  = 1'b0;
					res_code_d   = '0;
					res_idx_d    = '0;
					unique case (mode_t'(mode))
						MODE_APPEND: begin
							if (count_q < DEPTH_CNT) begin
								tbl_we  = 1'b1;
								count_d = count_q + 1'b1;
							end else begin
								res_status_d = 1'b1;
							end
							state_d = ST_RESP;
						end
						MODE_BUILD: begin
							if (count_q < SLOTS_CNT) begin
								built_d = 1'b0;
								state_d = ST_RESP;
							end else begin
								state_d = ST_DIV;
							end
						end
						MODE_LOOKUP: begin
							slot_d  = '0;
							scan_d  = '0;
							state_d = built_q ? ST_IDX_SCAN : ST_TBL_SCAN;
						end
						MODE_CLEAR: begin
							count_d = '0;
							built_d = 1'b0;
							state_d = ST_RESP;
						end
					endcase
				end
			end

			// part = count / slots
			ST_DIV: begin
				quo_d   = quo_prod[QSH +: CW];
				pos_d   = count_q;
				slot_d  = '0;
				state_d = ST_BLD_RD;
			end

			// slot i: pos -= part, fetch the start of that entry
			ST_BLD_RD: begin
				pos_d     = pos_next;
				tbl_raddr = pos_next[AW-1:0];
				state_d   = ST_BLD_WR;
			end

			ST_BLD_WR: begin
				idx_we = 1'b1;
				if (slot_q == SLOTS_LAST) begin
					built_d = 1'b1;
					state_d = ST_RESP;
				end else begin
					slot_d  = slot_q + 1'b1;
					state_d = ST_BLD_RD;
				end
			end

			// probe slots in order, one read per cycle, check in the next cycle
			ST_IDX_SCAN: begin
				issue = (slot_q < SLOTS_SW);
				if (issue) begin
					idx_raddr = slot_q[IW-1:0];
					slot_d    = slot_q + 1'b1;
				end
				pend_d = issue;
				if (pend_s1 && idx_hit) begin
					pend_d  = 1'b0;
					scan_d  = {{(CW-AW){1'b0}}, idx_rd_pos};
					state_d = ST_TBL_SCAN;
				end else if (!issue && !pend_s1) begin
					scan_d  = '0;
					state_d = ST_TBL_SCAN;
				end
			end

			// linear scan, one entry read per cycle, compare in the next cycle
			ST_TBL_SCAN: begin
				issue = (scan_q < count_q);
				if (issue) begin
					tbl_raddr = scan_q[AW-1:0];
					scan_d    = scan_q + 1'b1;
				end
				pend_d = issue;
				pidx_d = scan_q;
				if (pend_s1 && tbl_match) begin
					pend_d      = 1'b0;
					res_found_d = 1'b1;
					res_code_d  = tbl_rdata.code;
					res_idx_d   = pidx_ext[MATCH_W-1:0];
					state_d     = ST_RESP;
				end else if (!issue && !pend_s1) begin
					res_found_d = 1'b0;
					res_code_d  = CODE_NONE;
					res_idx_d   = '0;
					state_d     = ST_RESP;
				end
			end

			ST_RESP: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid_d = out_load || (out_valid_q && out_stall);

	// ---------------------------------------------------------------- registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			built_q     <= 1'b0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			built_q     <= built_d;
			pend_s1     <= pend_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		addr_d_reg: begin
			addr_q       <= addr_d;
			quo_q        <= quo_d;
			pos_q        <= pos_d;
			slot_q       <= slot_d;
			scan_q       <= scan_d;
			pidx_s1      <= pidx_d;
			res_status_q <= res_status_d;
			res_found_q  <= res_found_d;
			res_code_q   <= res_code_d;
			res_idx_q    <= res_idx_d;
		end
		if (out_load) begin
			status_q <= res_status_q;
			found_q  <= res_found_q;
			code_q   <= res_code_q;
			idx_q    <= res_idx_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign found        = found_q;
	assign country_code = code_q;
	assign match_index  = idx_q;

	// ---------------------------------------------------------------- checks
`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_CNT)
		else $error("entry count beyond table depth");

	a_built_has_slots: assert property (@(posedge clk) disable iff (!arst_n)
		built_q |-> (count_q >= SLOTS_CNT))
		else $error("index marked built with too few entries");

	a_scan_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TBL_SCAN && pend_s1) |-> (pidx_s1 < count_q))
		else $error("scan compared an entry beyond the table");

	a_resp_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESP && !out_valid_q) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("result not moved to output register");
`endif

endmodule

`default_nettype wire
